>>> rtl/core/pdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdt_pkg: shared codes and constants of the periodic deadline timer
// Item kinds, configuration register indexes, unit codes and unit scale
// factors used by the timer core and its serial scaler.
// ----------------------------------------------------------------------------
package pdt_pkg;

    // item kind carried on s_tuser
    localparam logic [1:0] MODE_ARM     = 2'd0;
    localparam logic [1:0] MODE_POLL    = 2'd1;
    localparam logic [1:0] MODE_CONSUME = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_RAW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_FLAGS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_FIRE = 2'd2;

    // unit field of timer_flags (bits 2:0); bit 3 selects absolute mode
    localparam int unsigned FLAG_ABS_BIT = 3;
    localparam logic [2:0] UNIT_MS = 3'b000;
    localparam logic [2:0] UNIT_S  = 3'b001;
    localparam logic [2:0] UNIT_US = 3'b010;
    localparam logic [2:0] UNIT_NS = 3'b100;

    // scale factors to nanoseconds
    localparam int unsigned MULT_W = 30;
    localparam logic [MULT_W-1:0] NS_PER_S  = 30'd1_000_000_000;
    localparam logic [MULT_W-1:0] NS_PER_MS = 30'd1_000_000;
    localparam logic [MULT_W-1:0] NS_PER_US = 30'd1_000;
    localparam logic [MULT_W-1:0] NS_PER_NS = 30'd1;

    // result field width and expiration count clamp
    localparam int unsigned COUNT_W = 63;
    localparam logic [63:0] EXTRA_CLAMP = 64'h7FFF_FFFF_FFFF_FFFE;

endpackage

>>> rtl/core/pdt_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdt_mul: serial shift-add scaler with saturation
// Consumes one bit of the scale factor per cycle; flags saturation when the
// product leaves the W-bit range.
// ----------------------------------------------------------------------------
module pdt_mul
    import pdt_pkg::*;
#(
    parameter int unsigned W = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [W-1:0]      multiplicand,
    input  logic [MULT_W-1:0] multiplier,
    output logic              done,
    output logic [W-1:0]      product,
    output logic              saturated
);

    logic              busy_reg, busy_next;
    logic [W-1:0]      addend_reg, addend_next;
    logic              addend_ovf_reg, addend_ovf_next;
    logic [MULT_W-1:0] mrem_reg, mrem_next;
    logic [W-1:0]      acc_reg, acc_next;
    logic              sat_reg, sat_next;
    logic [W:0]        sum;

    assign sum = {1'b0, acc_reg} + {1'b0, addend_reg};

    always_comb
    begin
        busy_next       = busy_reg;
        addend_next     = addend_reg;
        addend_ovf_next = addend_ovf_reg;
        mrem_next       = mrem_reg;
        acc_next        = acc_reg;
        sat_next        = sat_reg;
        if (start)
        begin
            busy_next       = 1'b1;
            addend_next     = multiplicand;
            addend_ovf_next = 1'b0;
            mrem_next       = multiplier;
            acc_next        = '0;
            sat_next        = 1'b0;
        end
        else if (busy_reg)
        begin
            if (mrem_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                // add the shifted operand where the scale bit is set
                if (mrem_reg[0])
                begin
                    acc_next = sum[W-1:0];
                    if (sum[W] || addend_ovf_reg)
                    begin
                        sat_next = 1'b1;
                    end
                end
                addend_ovf_next = addend_ovf_reg | addend_reg[W-1];
                addend_next     = {addend_reg[W-2:0], 1'b0};
                mrem_next       = {1'b0, mrem_reg[MULT_W-1:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            addend_reg     <= '0;
            addend_ovf_reg <= 1'b0;
            mrem_reg       <= '0;
            acc_reg        <= '0;
            sat_reg        <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            addend_reg     <= addend_next;
            addend_ovf_reg <= addend_ovf_next;
            mrem_reg       <= mrem_next;
            acc_reg        <= acc_next;
            sat_reg        <= sat_next;
        end
    end

    assign done      = busy_reg && (mrem_reg == '0);
    assign product   = acc_reg;
    assign saturated = sat_reg;

endmodule

>>> rtl/core/pdt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdt_div: radix-2 restoring divider
// Shifts one quotient bit in per cycle and produces quotient and remainder.
// ----------------------------------------------------------------------------
module pdt_div
#(
    parameter int unsigned W = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);

    localparam int unsigned CNT_W = $clog2(W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     dvs_reg, dvs_next;
    logic [W:0]       shifted;
    logic [W+1:0]     trial;

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // keep the trial difference unless it went negative
            if (trial[W+1])
            begin
                rem_next = shifted[W-1:0];
            end
            else
            begin
                rem_next = trial[W-1:0];
            end
            quo_next = {quo_reg[W-2:0], ~trial[W+1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> rtl/core/periodic_deadline_timer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_deadline_timer_unit: deadline timer with reload and overrun count
// Arms a deadline from a scaled count, reports due expirations and advances
// a periodic deadline to the next period boundary on consume.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | beat
//  --------+-----------+--------------------+-----------------------------------
//  s_*     | in        | s_tvalid/s_tready  | kind on tuser, now/wall on tdata
//  m_*     | out       | m_tvalid/m_tready  | count, valid, deadline, error
//  cfg_*   | in        | cfg_valid/cfg_ready| register index and write data
//
//  Arm beat: S_EVAL, S_MUL until the serial scaler is done, S_ADJ, S_ADD, S_DONE.
//  Poll beat that needs a division: S_EVAL, S_DIV until the radix-2 divider is
//  done, S_DONE; a consume adds S_FIN before S_DONE. A beat that needs no division,
//  or an arm with a bad unit combination, goes from S_EVAL straight to S_DONE.
//  One beat at a time: s_tready is high only while the sequencer is idle; a
//  finished result waits in the output register, and the sequencer stalls in
//  its last state only while that register is still full.
//  Reset clears the deadline, the reload interval and all config registers.
// ----------------------------------------------------------------------------
module periodic_deadline_timer_unit
    import pdt_pkg::*;
#(
    parameter int unsigned TIME_WIDTH = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [127:0]         s_tdata,   // [63:0] now_time, [127:64] wall_clock
    input  logic [1:0]           s_tuser,   // [1:0] mode
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [135:0]         m_tdata,   // [62:0] expiration_count,
                                            // [63] deadline_valid,
                                            // [127:64] next_deadline,
                                            // [128] arm_error, [135:129] zero
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    localparam int unsigned TW = TIME_WIDTH;
    localparam logic [TW-1:0] TMAX = {TW{1'b1}};

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_EVAL = 8'b0000_0010,
        S_MUL  = 8'b0000_0100,
        S_ADJ  = 8'b0000_1000,
        S_ADD  = 8'b0001_0000,
        S_DIV  = 8'b0010_0000,
        S_FIN  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [TW-1:0] count_raw_reg, count_raw_next;
    logic [3:0]    flags_reg, flags_next;
    logic          single_fire_reg, single_fire_next;

    // timer state
    logic [TW-1:0] deadline_reg, deadline_next;
    logic          armed_reg, armed_next;
    logic [TW-1:0] reload_reg, reload_next;

    // captured beat and working values
    logic [1:0]         mode_reg, mode_next;
    logic [TW-1:0]      now_reg, now_next;
    logic [TW-1:0]      wall_reg, wall_next;
    logic [TW-1:0]      off_reg, off_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               err_reg, err_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [COUNT_W-1:0] o_count_reg, o_count_next;
    logic               o_armed_reg, o_armed_next;
    logic [63:0]        o_deadline_reg, o_deadline_next;
    logic               o_err_reg, o_err_next;

    // serial units
    logic              mul_start, mul_done, mul_sat;
    logic [TW-1:0]     mul_prod;
    logic [MULT_W-1:0] mul_factor;
    logic              unit_ok;
    logic              div_start, div_done;
    logic [TW-1:0]     div_quo, div_rem;

    // shared datapath terms
    logic [TW:0]   elapsed;     // now - deadline, borrow in the top bit
    logic [TW-1:0] dur;
    logic [TW:0]   dur_minus_wall;
    logic [TW:0]   now_plus_off;
    logic [63:0]   extra;
    logic          load_out;

    assign elapsed        = {1'b0, now_reg} - {1'b0, deadline_reg};
    assign dur            = mul_sat ? TMAX : mul_prod;
    assign dur_minus_wall = {1'b0, dur} - {1'b0, wall_reg};
    assign now_plus_off   = {1'b0, now_reg} + {1'b0, off_reg};
    assign extra          = (64'(div_quo) > EXTRA_CLAMP) ? EXTRA_CLAMP : 64'(div_quo);

    // pick the scale factor; more than one unit bit is an error
    always_comb
    begin
        unit_ok    = 1'b1;
        mul_factor = NS_PER_MS;
        case (flags_reg[2:0])
            UNIT_MS: mul_factor = NS_PER_MS;
            UNIT_S:  mul_factor = NS_PER_S;
            UNIT_US: mul_factor = NS_PER_US;
            UNIT_NS: mul_factor = NS_PER_NS;
            default: unit_ok    = 1'b0;
        endcase
    end

    assign mul_start = (state_reg == S_EVAL) && (mode_reg == MODE_ARM) && unit_ok;
    assign div_start = (state_reg == S_EVAL) && (mode_reg != MODE_ARM) && armed_reg
                       && !elapsed[TW] && (reload_reg != '0);

    pdt_mul #(
        .W (TW)
    ) u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplicand (count_raw_reg),
        .multiplier   (mul_factor),
        .done         (mul_done),
        .product      (mul_prod),
        .saturated    (mul_sat)
    );

    pdt_div #(
        .W (TW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (elapsed[TW-1:0]),
        .divisor   (reload_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign load_out = (state_reg == S_DONE) && (!m_valid_reg || m_tready);

    always_comb
    begin
        state_next       = state_reg;
        count_raw_next   = count_raw_reg;
        flags_next       = flags_reg;
        single_fire_next = single_fire_reg;
        deadline_next    = deadline_reg;
        armed_next       = armed_reg;
        reload_next      = reload_reg;
        mode_next        = mode_reg;
        now_next         = now_reg;
        wall_next        = wall_reg;
        off_next         = off_reg;
        cnt_next         = cnt_reg;
        err_next         = err_reg;
        m_valid_next     = m_valid_reg;
        o_count_next     = o_count_reg;
        o_armed_next     = o_armed_reg;
        o_deadline_next  = o_deadline_reg;
        o_err_next       = o_err_reg;

        // register writes; out-of-range indexes are dropped
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_COUNT_RAW:   count_raw_next   = cfg_data[TW-1:0];
                CFG_TIMER_FLAGS: flags_next       = cfg_data[3:0];
                CFG_SINGLE_FIRE: single_fire_next = cfg_data[0];
                default:         ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    mode_next  = s_tuser;
                    now_next   = s_tdata[TW-1:0];
                    wall_next  = s_tdata[64+TW-1:64];
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cnt_next = '0;
                err_next = 1'b0;
                if (mode_reg == MODE_ARM)
                begin
                    if (unit_ok)
                    begin
                        state_next = S_MUL;
                    end
                    else
                    begin
                        // bad unit combination: disarm and flag
                        err_next      = 1'b1;
                        armed_next    = 1'b0;
                        deadline_next = '0;
                        reload_next   = '0;
                        state_next    = S_DONE;
                    end
                end
                else if (!armed_reg || elapsed[TW])
                begin
                    state_next = S_DONE;
                end
                else if (reload_reg == '0)
                begin
                    // single expiration; consume disarms
                    cnt_next = COUNT_W'(1);
                    if (mode_reg == MODE_CONSUME)
                    begin
                        armed_next    = 1'b0;
                        deadline_next = '0;
                        reload_next   = '0;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    if (flags_reg[FLAG_ABS_BIT])
                    begin
                        off_next    = dur_minus_wall[TW] ? '0 : dur_minus_wall[TW-1:0];
                        reload_next = '0;
                    end
                    else
                    begin
                        off_next    = dur;
                        reload_next = single_fire_reg ? '0 : dur;
                    end
                    state_next = S_ADJ;
                end
            end
            S_ADJ:
            begin
                // saturating now + offset
                deadline_next = now_plus_off[TW] ? TMAX : now_plus_off[TW-1:0];
                armed_next    = 1'b1;
                state_next    = S_ADD;
            end
            S_ADD:
            begin
                state_next = S_DONE;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    cnt_next = extra[COUNT_W-1:0] + COUNT_W'(1);
                    off_next = reload_reg - div_rem;
                    if (mode_reg == MODE_CONSUME)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_FIN:
            begin
                // advance to the next boundary; disarm if it runs off the end
                if (now_plus_off[TW])
                begin
                    armed_next    = 1'b0;
                    deadline_next = '0;
                    reload_next   = '0;
                end
                else
                begin
                    deadline_next = now_plus_off[TW-1:0];
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // output register: take the result, drop it once taken
        if (load_out)
        begin
            m_valid_next    = 1'b1;
            o_count_next    = cnt_reg;
            o_armed_next    = armed_reg;
            o_deadline_next = armed_reg ? 64'(deadline_reg) : 64'd0;
            o_err_next      = err_reg;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_raw_reg   <= '0;
            flags_reg       <= '0;
            single_fire_reg <= 1'b0;
            deadline_reg    <= '0;
            armed_reg       <= 1'b0;
            reload_reg      <= '0;
            mode_reg        <= '0;
            now_reg         <= '0;
            wall_reg        <= '0;
            off_reg         <= '0;
            cnt_reg         <= '0;
            err_reg         <= 1'b0;
            m_valid_reg     <= 1'b0;
            o_count_reg     <= '0;
            o_armed_reg     <= 1'b0;
            o_deadline_reg  <= '0;
            o_err_reg       <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_raw_reg   <= count_raw_next;
            flags_reg       <= flags_next;
            single_fire_reg <= single_fire_next;
            deadline_reg    <= deadline_next;
            armed_reg       <= armed_next;
            reload_reg      <= reload_next;
            mode_reg        <= mode_next;
            now_reg         <= now_next;
            wall_reg        <= wall_next;
            off_reg         <= off_next;
            cnt_reg         <= cnt_next;
            err_reg         <= err_next;
            m_valid_reg     <= m_valid_next;
            o_count_reg     <= o_count_next;
            o_armed_reg     <= o_armed_next;
            o_deadline_reg  <= o_deadline_next;
            o_err_reg       <= o_err_next;
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {7'd0, o_err_reg, o_deadline_reg, o_armed_reg, o_count_reg};

endmodule

>>> rtl/core/pdt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdt_checker: port-level checks of the periodic deadline timer
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module pdt_checker
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [135:0]         m_tdata
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // one beat in flight: ready drops right after an accept
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a beat is in flight");

    // an unarmed timer reports a zero deadline
    a_unarmed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[63] |-> m_tdata[127:64] == 64'd0)
        else $error("deadline reported while unarmed");

    // an arm error leaves the timer unarmed and reports no expirations
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[128] |-> !m_tdata[63] && m_tdata[62:0] == 63'd0)
        else $error("arm error with armed timer or nonzero count");

    // padding bits stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[135:129] == 7'd0)
        else $error("nonzero padding in result beat");

endmodule

bind periodic_deadline_timer_unit pdt_checker u_pdt_checker (.*);
